FILE: rtl/core/multi_shape_envelope_generator_macros.svh
// Assertion macros used by the envelope generator back end (mseg_back).
// Each macro expects signals named clock and reset in the calling module.
`ifndef MULTI_SHAPE_ENVELOPE_GENERATOR_MACROS_SVH
`define MULTI_SHAPE_ENVELOPE_GENERATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MSEG_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MSEG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/mseg_pkg.sv
// Shared constants, types and helpers for the multi-shape envelope generator.
// No dependencies; every RTL module and interface imports this package.
package mseg_pkg;

   // Length registers keep this many bits; the elapsed counter has three more.
   localparam int LEN_BITS    = 20;
   localparam int CNT_W       = LEN_BITS + 3;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   localparam int VEL_W       = 7;
   localparam int LVL_W       = 16;
   localparam int MAG_W       = LVL_W + 1;
   localparam int PROD_W      = MAG_W + LEN_BITS;
   localparam int QCNT_W      = $clog2(MAG_W);
   localparam int SEG_W       = 3;

   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = (LEN_BITS > LVL_W) ? LEN_BITS : LVL_W;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic signed [LVL_W-1:0] LVL_MAX = {1'b0, {(LVL_W-1){1'b1}}};
   localparam logic signed [LVL_W-1:0] LVL_MIN = {1'b1, {(LVL_W-1){1'b0}}};

   // Velocity follower: level = velocity * 32768 / 127
   localparam logic [MAG_W-1:0]    VEL_SCALE   = MAG_W'(32768);
   localparam logic [LEN_BITS-1:0] VEL_DIVISOR = LEN_BITS'(127);

   // Item kinds
   localparam logic KIND_TRIGGER = 1'b0;
   localparam logic KIND_TICK    = 1'b1;

   // Segment positions inside a shape
   localparam logic [SEG_W-1:0] SEG_FIRST  = SEG_W'(0);
   localparam logic [SEG_W-1:0] SEG_SECOND = SEG_W'(1);
   localparam logic [SEG_W-1:0] SEG_THIRD  = SEG_W'(2);
   localparam logic [SEG_W-1:0] SEG_FOURTH = SEG_W'(3);

   typedef enum logic [1:0] {
      MODE_STEP,
      MODE_ADHR,
      MODE_RAMP,
      MODE_VELOCITY
   } mseg_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SHAPE_MODE,
      CSR_ATTACK_LEN,
      CSR_DECAY_LEN,
      CSR_RELEASE_LEN,
      CSR_HOLD_LEN,
      CSR_RAMP_LEN,
      CSR_PEAK_LEVEL,
      CSR_SUSTAIN_LEVEL
   } mseg_csr_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_SCAN,
      F_PUSH
   } mseg_front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_MUL,
      B_DIV,
      B_FIN,
      B_OUT
   } mseg_back_state_type;

   typedef struct packed {
      mseg_mode_type              shape_mode;
      logic [LEN_BITS-1:0]        attack_len;
      logic [LEN_BITS-1:0]        decay_len;
      logic [LEN_BITS-1:0]        release_len;
      logic [LEN_BITS-1:0]        hold_len;
      logic [LEN_BITS-1:0]        ramp_len;
      logic signed [LVL_W-1:0]    peak_level;
      logic [LVL_W-1:0]           sustain_level;
   } mseg_cfg_type;

   // One classified item: level = base +/- (coef_mag * mult / divisor)
   typedef struct packed {
      logic [MAG_W-1:0]           coef_mag;
      logic                       coef_neg;
      logic [LEN_BITS-1:0]        mult;
      logic [LEN_BITS-1:0]        divisor;
      logic signed [LVL_W-1:0]    base;
      logic                       expired;
      logic                       active;
   } mseg_job_type;

   typedef struct packed {
      logic                       valid;
      mseg_job_type               job;
   } mseg_qwrite_type;

   typedef struct packed {
      logic                       empty;
      mseg_job_type               job;
   } mseg_qread_type;

   // Clamp an 18-bit signed value to the 16-bit level range.
   function automatic logic signed [LVL_W-1:0] sat_level(input logic signed [LVL_W+1:0] v);
      logic signed [LVL_W-1:0] r;
      if ((v[LVL_W+1:LVL_W-1] == 3'b000) || (v[LVL_W+1:LVL_W-1] == 3'b111)) begin
         r = v[LVL_W-1:0];
      end else if (v[LVL_W+1]) begin
         r = LVL_MIN;
      end else begin
         r = LVL_MAX;
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/mseg_req_if.sv
// Input channel of the envelope generator: valid/ready plus one item.
// Depends on mseg_pkg.
interface mseg_req_if;
   import mseg_pkg::*;

   logic             valid;
   logic             ready;
   logic             kind;
   logic [VEL_W-1:0] velocity;

   modport source (output valid, output kind, output velocity, input ready);
   modport sink   (input valid, input kind, input velocity, output ready);
endinterface

FILE: rtl/core/mseg_rsp_if.sv
// Result channel of the envelope generator: valid/ready plus one level beat.
// Depends on mseg_pkg.
interface mseg_rsp_if;
   import mseg_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [LVL_W-1:0] level;
   logic                    expired;
   logic                    active;

   modport source (output valid, output level, output expired, output active, input ready);
   modport sink   (input valid, input level, input expired, input active, output ready);
endinterface

FILE: rtl/core/mseg_queue.sv
// Small job FIFO between the classifier and the arithmetic back end.
// Depends on mseg_pkg.
module mseg_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  mseg_pkg::mseg_qwrite_type q_write,
   output logic                      q_full,
   input  logic                      q_pop,
   output mseg_pkg::mseg_qread_type  q_read
);
   import mseg_pkg::*;

   mseg_job_type      entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign q_full       = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign q_read.empty = (count_ff == '0);
   assign q_read.job   = entry_ff[rd_ptr_ff];

   assign do_push = q_write.valid && !q_full;
   assign do_pop  = q_pop && !q_read.empty;

   // pointer and fill-count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= q_write.job;
      end
   end

endmodule

FILE: rtl/core/mseg_front.sv
// Front end: accepts items, keeps elapsed time and run state, and walks the
// shape's segments to classify each item into an arithmetic job. Depends on mseg_pkg.
module mseg_front (
   input  logic                      clock,
   input  logic                      reset,
   input  mseg_pkg::mseg_cfg_type    cfg,
   mseg_req_if.sink                  req_chan,
   input  logic                      q_full,
   output mseg_pkg::mseg_qwrite_type q_write
);
   import mseg_pkg::*;

   mseg_front_state_type    state_ff, state_in;
   logic [CNT_W-1:0]        elapsed_ff, elapsed_in;
   logic                    running_ff, running_in;
   logic [VEL_W-1:0]        velocity_ff, velocity_in;
   logic signed [LVL_W-1:0] sus_ff, sus_in;
   logic [SEG_W-1:0]        seg_ff, seg_in;
   logic [CNT_W-1:0]        base_ff, base_in;
   mseg_job_type            job_ff, job_in;

   localparam logic signed [2*LVL_W:0] SUS_ROUND = (2*LVL_W+1)'((1 << (LVL_W-1)) - 1);

   function automatic logic [LEN_BITS-1:0] at_least_one(input logic [LEN_BITS-1:0] v);
      return (v == '0) ? LEN_BITS'(1) : v;
   endfunction

   function automatic logic [MAG_W-1:0] magnitude(input logic [MAG_W-1:0] v);
      return v[MAG_W-1] ? MAG_W'(~v + 1'b1) : v;
   endfunction

   // sustain = sat16(peak * sustain_level / 32768), truncated toward zero
   logic signed [2*LVL_W:0] sus_prod;
   logic signed [2*LVL_W:0] sus_adj;
   logic signed [LVL_W+1:0] sus_quot;
   logic signed [LVL_W-1:0] sus_calc;

   assign sus_prod = cfg.peak_level * $signed({1'b0, cfg.sustain_level});
   assign sus_adj  = sus_prod + (sus_prod[2*LVL_W] ? SUS_ROUND : '0);
   assign sus_quot = sus_adj[2*LVL_W:LVL_W-1];
   assign sus_calc = sat_level(sus_quot);

   // segment length and count for the current mode
   logic [LEN_BITS-1:0] seg_len;
   logic [SEG_W-1:0]    seg_count;
   logic [CNT_W-1:0]    seg_end;
   logic                seg_hit;
   logic [LEN_BITS-1:0] seg_offset;

   always_comb begin
      seg_len   = '0;
      seg_count = '0;
      unique case (cfg.shape_mode)
         MODE_STEP: begin
            seg_count = SEG_W'(1);
            seg_len   = cfg.hold_len;
         end
         MODE_ADHR: begin
            seg_count = SEG_W'(4);
            unique case (seg_ff)
               SEG_FIRST:  seg_len = at_least_one(cfg.attack_len);
               SEG_SECOND: seg_len = at_least_one(cfg.decay_len);
               SEG_THIRD:  seg_len = cfg.hold_len;
               SEG_FOURTH: seg_len = cfg.release_len;
               default:    seg_len = '0;
            endcase
         end
         MODE_RAMP: begin
            seg_count = SEG_W'(2);
            seg_len   = (seg_ff == SEG_FIRST) ? at_least_one(cfg.ramp_len) : cfg.hold_len;
         end
         MODE_VELOCITY: begin
            seg_count = SEG_W'(1);
            seg_len   = at_least_one(cfg.hold_len);
         end
      endcase
   end

   assign seg_end    = base_ff + CNT_W'(seg_len);
   assign seg_hit    = (elapsed_ff < seg_end);
   assign seg_offset = LEN_BITS'(elapsed_ff - base_ff);

   // job for an item that falls inside the current segment
   logic signed [MAG_W-1:0] peak_ext, sus_ext, sus_minus_peak;
   mseg_job_type            hit_job;

   assign peak_ext       = {cfg.peak_level[LVL_W-1], cfg.peak_level};
   assign sus_ext        = {sus_ff[LVL_W-1], sus_ff};
   assign sus_minus_peak = sus_ext - peak_ext;

   always_comb begin
      hit_job         = '0;
      hit_job.divisor = LEN_BITS'(1);
      hit_job.mult    = seg_offset;
      hit_job.active  = 1'b1;
      unique case (cfg.shape_mode)
         MODE_STEP: begin
            hit_job.base = cfg.peak_level;
         end
         MODE_ADHR: begin
            unique case (seg_ff)
               SEG_FIRST: begin
                  hit_job.coef_mag = magnitude(peak_ext);
                  hit_job.coef_neg = peak_ext[MAG_W-1];
                  hit_job.divisor  = at_least_one(cfg.attack_len);
               end
               SEG_SECOND: begin
                  hit_job.base     = cfg.peak_level;
                  hit_job.coef_mag = magnitude(sus_minus_peak);
                  hit_job.coef_neg = sus_minus_peak[MAG_W-1];
                  hit_job.divisor  = at_least_one(cfg.decay_len);
               end
               SEG_THIRD: begin
                  hit_job.base = sus_ff;
               end
               SEG_FOURTH: begin
                  // falls from sustain toward zero
                  hit_job.base     = sus_ff;
                  hit_job.coef_mag = magnitude(sus_ext);
                  hit_job.coef_neg = !sus_ext[MAG_W-1];
                  hit_job.divisor  = cfg.release_len;
               end
               default: begin
                  hit_job.base = '0;
               end
            endcase
         end
         MODE_RAMP: begin
            if (seg_ff == SEG_FIRST) begin
               hit_job.coef_mag = magnitude(peak_ext);
               hit_job.coef_neg = peak_ext[MAG_W-1];
               hit_job.divisor  = at_least_one(cfg.ramp_len);
            end else begin
               hit_job.base = cfg.peak_level;
            end
         end
         MODE_VELOCITY: begin
            hit_job.coef_mag = VEL_SCALE;
            hit_job.mult     = LEN_BITS'(velocity_ff);
            hit_job.divisor  = VEL_DIVISOR;
         end
      endcase
   end

   // state machine: next state and register inputs
   always_comb begin
      state_in      = state_ff;
      elapsed_in    = elapsed_ff;
      running_in    = running_ff;
      velocity_in   = velocity_ff;
      sus_in        = sus_ff;
      seg_in        = seg_ff;
      base_in       = base_ff;
      job_in        = job_ff;
      req_chan.ready = 1'b0;
      q_write.valid = 1'b0;
      q_write.job   = job_ff;
      unique case (state_ff)
         F_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               sus_in  = sus_calc;
               seg_in  = SEG_FIRST;
               base_in = '0;
               if (req_chan.kind == KIND_TRIGGER) begin
                  velocity_in = req_chan.velocity;
                  elapsed_in  = '0;
                  running_in  = 1'b1;
                  state_in    = F_SCAN;
               end else begin
                  if (elapsed_ff != CNT_MAX) begin
                     elapsed_in = elapsed_ff + 1'b1;
                  end
                  if (running_ff) begin
                     state_in = F_SCAN;
                  end else begin
                     job_in         = '0;
                     job_in.divisor = LEN_BITS'(1);
                     state_in       = F_PUSH;
                  end
               end
            end
         end
         F_SCAN: begin
            if (seg_ff == seg_count) begin
               // past the last segment: envelope ends here
               job_in         = '0;
               job_in.divisor = LEN_BITS'(1);
               job_in.expired = 1'b1;
               job_in.base    = (cfg.shape_mode == MODE_RAMP) ? cfg.peak_level : '0;
               running_in     = 1'b0;
               state_in       = F_PUSH;
            end else if (seg_hit) begin
               job_in   = hit_job;
               state_in = F_PUSH;
            end else begin
               base_in = seg_end;
               seg_in  = seg_ff + 1'b1;
            end
         end
         F_PUSH: begin
            q_write.valid = 1'b1;
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= F_IDLE;
         elapsed_ff  <= '0;
         running_ff  <= 1'b0;
         velocity_ff <= '0;
      end else begin
         state_ff    <= state_in;
         elapsed_ff  <= elapsed_in;
         running_ff  <= running_in;
         velocity_ff <= velocity_in;
      end
   end

   always_ff @(posedge clock) begin
      sus_ff  <= sus_in;
      seg_ff  <= seg_in;
      base_ff <= base_in;
      job_ff  <= job_in;
   end

endmodule

FILE: rtl/core/mseg_back.sv
// Back end: multiplies, runs a restoring divider one quotient bit per cycle,
// then offsets and clamps the level and holds it for the result beat. Depends on mseg_pkg.
module mseg_back (
   input  logic                     clock,
   input  logic                     reset,
   input  mseg_pkg::mseg_qread_type q_read,
   output logic                     q_pop,
   mseg_rsp_if.source               rsp_chan
);
   import mseg_pkg::*;
   `include "multi_shape_envelope_generator_macros.svh"

   mseg_back_state_type     state_ff, state_in;
   mseg_job_type            job_ff, job_in;
   logic [LEN_BITS-1:0]     rem_ff, rem_in;
   logic [MAG_W-1:0]        low_ff, low_in;
   logic [MAG_W-1:0]        quot_ff, quot_in;
   logic [QCNT_W-1:0]       step_ff, step_in;
   logic signed [LVL_W-1:0] level_ff, level_in;

   // product; quotient is known to fit MAG_W bits, so the top bits seed the remainder
   logic [PROD_W-1:0] prod;
   assign prod = PROD_W'(job_ff.coef_mag) * PROD_W'(job_ff.mult);

   // one restoring step
   logic [LEN_BITS:0] shifted, div_ext, diff;
   logic              fits;
   assign shifted = {rem_ff, low_ff[MAG_W-1]};
   assign div_ext = {1'b0, job_ff.divisor};
   assign fits    = (shifted >= div_ext);
   assign diff    = shifted - div_ext;

   // final offset from the segment base
   logic signed [LVL_W+1:0] base_ext, quot_ext, level_sum;
   assign base_ext  = {{2{job_ff.base[LVL_W-1]}}, job_ff.base};
   assign quot_ext  = {1'b0, quot_ff};
   assign level_sum = job_ff.coef_neg ? (base_ext - quot_ext) : (base_ext + quot_ext);

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      rem_in   = rem_ff;
      low_in   = low_ff;
      quot_in  = quot_ff;
      step_in  = step_ff;
      level_in = level_ff;
      q_pop    = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_read.empty) begin
               q_pop    = 1'b1;
               job_in   = q_read.job;
               state_in = B_MUL;
            end
         end
         B_MUL: begin
            rem_in   = prod[PROD_W-1:MAG_W];
            low_in   = prod[MAG_W-1:0];
            quot_in  = '0;
            step_in  = '0;
            state_in = B_DIV;
         end
         B_DIV: begin
            rem_in  = fits ? diff[LEN_BITS-1:0] : shifted[LEN_BITS-1:0];
            low_in  = {low_ff[MAG_W-2:0], 1'b0};
            quot_in = {quot_ff[MAG_W-2:0], fits};
            step_in = step_ff + 1'b1;
            if (step_ff == QCNT_W'(MAG_W-1)) begin
               state_in = B_FIN;
            end
         end
         B_FIN: begin
            level_in = sat_level(level_sum);
            state_in = B_OUT;
         end
         B_OUT: begin
            if (rsp_chan.ready) begin
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   assign rsp_chan.valid   = (state_ff == B_OUT);
   assign rsp_chan.level   = level_ff;
   assign rsp_chan.expired = job_ff.expired;
   assign rsp_chan.active  = job_ff.active;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      rem_ff   <= rem_in;
      low_ff   <= low_in;
      quot_ff  <= quot_in;
      step_ff  <= step_in;
      level_ff <= level_in;
   end

   // checks
   `MSEG_ASSERT_IMPL(a_rem_below_divisor, state_ff == B_DIV, rem_ff < job_ff.divisor, "divider remainder not below divisor")
   `MSEG_ASSERT_NEXT(a_pop_starts_multiply, q_pop, state_ff == B_MUL, "popped job did not start multiply")
   `MSEG_ASSERT_IMPL(a_expired_not_active, rsp_chan.valid && rsp_chan.expired, !rsp_chan.active, "expired beat still marked active")

endmodule

FILE: rtl/core/multi_shape_envelope_generator.sv
// Multi-shape envelope generator. Path from accepted item to result valid
// (front: accept, zero to five segment checks, push; back: pop, multiply,
// 17-step divide, clamp). The front end can accept a new item while the back end's
// one-bit-per-cycle restoring divider is still working on an earlier one.
// Reset (synchronous): envelope idle, counter and velocity zero, registers to defaults.
// Depends on mseg_pkg, mseg_req_if, mseg_rsp_if, mseg_queue, mseg_front, mseg_back.
module multi_shape_envelope_generator (
   input  logic                               clock,
   input  logic                               reset,
   mseg_req_if.sink                           req_chan,
   mseg_rsp_if.source                         rsp_chan,
   input  logic                               csr_we,
   input  logic [mseg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mseg_pkg::CSR_DATA_W-1:0]    csr_data
);
   import mseg_pkg::*;

   mseg_cfg_type    cfg_ff, cfg_in;
   mseg_qwrite_type q_write;
   mseg_qread_type  q_read;
   logic            q_full;
   logic            q_pop;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (mseg_csr_type'(csr_index))
            CSR_SHAPE_MODE:    cfg_in.shape_mode    = mseg_mode_type'(csr_data[1:0]);
            CSR_ATTACK_LEN:    cfg_in.attack_len    = csr_data[LEN_BITS-1:0];
            CSR_DECAY_LEN:     cfg_in.decay_len     = csr_data[LEN_BITS-1:0];
            CSR_RELEASE_LEN:   cfg_in.release_len   = csr_data[LEN_BITS-1:0];
            CSR_HOLD_LEN:      cfg_in.hold_len      = csr_data[LEN_BITS-1:0];
            CSR_RAMP_LEN:      cfg_in.ramp_len      = csr_data[LEN_BITS-1:0];
            CSR_PEAK_LEVEL:    cfg_in.peak_level    = csr_data[LVL_W-1:0];
            CSR_SUSTAIN_LEVEL: cfg_in.sustain_level = csr_data[LVL_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.shape_mode    <= MODE_ADHR;
         cfg_ff.attack_len    <= LEN_BITS'(480);
         cfg_ff.decay_len     <= LEN_BITS'(4800);
         cfg_ff.release_len   <= LEN_BITS'(9600);
         cfg_ff.hold_len      <= LEN_BITS'(4800);
         cfg_ff.ramp_len      <= LEN_BITS'(24000);
         cfg_ff.peak_level    <= LVL_MAX;
         cfg_ff.sustain_level <= LVL_W'(9830);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mseg_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_write  (q_write)
   );

   mseg_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_write (q_write),
      .q_full  (q_full),
      .q_pop   (q_pop),
      .q_read  (q_read)
   );

   mseg_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_read   (q_read),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

FILE: test/tb_top.sv
// Testbench for multi_shape_envelope_generator: directed script, then random note sequences.
// Levels are predicted in-bench, every result beat is checked in order.
// Depends on mseg_pkg, mseg_req_if, mseg_rsp_if and the generator RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mseg_pkg::*;

   localparam int unsigned LEN_MAX     = (1 << LEN_BITS) - 1;
   localparam int          CYCLE_LIMIT = 400000;
   localparam int          PHASES      = 13;
   localparam int          PHASE_ITEMS = 100;

   typedef struct packed {
      logic signed [LVL_W-1:0] level;
      logic                    expired;
      logic                    active;
   } level_beat_type;

   typedef struct {
      bit                  is_write;
      mseg_csr_type        idx;
      int unsigned         data;
      logic                kind;
      logic [VEL_W-1:0]    vel;
      bit                  known;
      level_beat_type      beat;
   } script_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   mseg_req_if req_bus ();
   mseg_rsp_if rsp_bus ();

   multi_shape_envelope_generator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Predictor copy of the registers and the envelope state
   mseg_mode_type           cfg_mode;
   logic [LEN_BITS-1:0]     cfg_attack, cfg_decay, cfg_release, cfg_hold, cfg_ramp;
   logic signed [LVL_W-1:0] cfg_peak;
   logic [LVL_W-1:0]        cfg_sustain;
   logic [CNT_W-1:0]        env_count;
   logic                    env_on;
   logic [VEL_W-1:0]        env_vel;

   level_beat_type levels_due [$];
   script_row_type script [$];
   int          beats_in;
   int          failures;
   int          cycles;
   bit          stall_done;
   logic        calm;

   // no idling on either side through this stretch of beats
   assign calm = (beats_in >= 500) && (beats_in < 750);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic longint clamp_q15(input longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic void config_write(input mseg_csr_type idx,
                                        input logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_SHAPE_MODE:    cfg_mode    = mseg_mode_type'(value[1:0]);
         CSR_ATTACK_LEN:    cfg_attack  = value[LEN_BITS-1:0];
         CSR_DECAY_LEN:     cfg_decay   = value[LEN_BITS-1:0];
         CSR_RELEASE_LEN:   cfg_release = value[LEN_BITS-1:0];
         CSR_HOLD_LEN:      cfg_hold    = value[LEN_BITS-1:0];
         CSR_RAMP_LEN:      cfg_ramp    = value[LEN_BITS-1:0];
         CSR_PEAK_LEVEL:    cfg_peak    = value[LVL_W-1:0];
         CSR_SUSTAIN_LEVEL: cfg_sustain = value[LVL_W-1:0];
         default: ;
      endcase
   endfunction

   // Advance the envelope by one input beat and return the level it yields
   function automatic void envelope_next(input logic kind, input logic [VEL_W-1:0] vel,
                                         output level_beat_type beat);
      longint t, pk, a, d, r, hl, rl, sus, lvl;
      bit done;
      if (kind == KIND_TRIGGER) begin
         env_vel   = vel;
         env_count = '0;
         env_on    = 1'b1;
      end else if (env_count != CNT_MAX) begin
         env_count = env_count + 1'b1;
      end
      lvl  = 0;
      done = 1'b0;
      t    = longint'(env_count);
      pk   = longint'(cfg_peak);
      hl   = cfg_hold;
      rl   = cfg_release;
      a    = (cfg_attack == 0) ? 1 : cfg_attack;
      d    = (cfg_decay == 0) ? 1 : cfg_decay;
      r    = (cfg_ramp == 0) ? 1 : cfg_ramp;
      if (env_on) begin
         case (cfg_mode)
            MODE_STEP: begin
               if (t < hl) lvl = pk;
               else done = 1'b1;
            end
            MODE_ADHR: begin
               sus = clamp_q15((pk * longint'(cfg_sustain)) / 32768);
               if (t < a) lvl = (pk * t) / a;
               else if (t - a < d) lvl = pk + ((sus - pk) * (t - a)) / d;
               else if (t - a - d < hl) lvl = sus;
               else if (t - a - d - hl < rl) lvl = sus - (sus * (t - a - d - hl)) / rl;
               else done = 1'b1;
            end
            MODE_RAMP: begin
               if (t < r) lvl = (pk * t) / r;
               else if (t < r + hl) lvl = pk;
               else begin
                  lvl  = pk;
                  done = 1'b1;
               end
            end
            default: begin
               if (t < ((hl == 0) ? 1 : hl)) lvl = clamp_q15((longint'(env_vel) * 32768) / 127);
               else done = 1'b1;
            end
         endcase
         if (done) env_on = 1'b0;
      end
      beat.level   = lvl[LVL_W-1:0];
      beat.expired = done;
      beat.active  = env_on;
   endfunction

   // Script builders for the directed part
   function automatic void add_write(input mseg_csr_type idx, input int unsigned data);
      script_row_type row;
      row = '{idx: CSR_SHAPE_MODE, default: 0};
      row.is_write = 1'b1;
      row.idx      = idx;
      row.data     = data;
      script = {script, row};
   endfunction

   function automatic void add_item(input logic kind, input int unsigned vel);
      script_row_type row;
      row = '{idx: CSR_SHAPE_MODE, default: 0};
      row.kind = kind;
      row.vel  = vel[VEL_W-1:0];
      script = {script, row};
   endfunction

   function automatic void add_known(input logic kind, input int unsigned vel,
                                     input logic signed [LVL_W-1:0] level,
                                     input logic expired, input logic active);
      script_row_type row;
      row = '{idx: CSR_SHAPE_MODE, default: 0};
      row.kind  = kind;
      row.vel   = vel[VEL_W-1:0];
      row.known = 1'b1;
      row.beat  = '{level, expired, active};
      script = {script, row};
   endfunction

   // Offer one input beat; called and returns just after a falling edge
   task automatic offer(input logic kind, input logic [VEL_W-1:0] vel,
                        input bit known, input level_beat_type known_beat);
      level_beat_type beat;
      while (!calm && $urandom_range(99) < 22) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid    = 1'b1;
      req_bus.kind     = kind;
      req_bus.velocity = vel;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      envelope_next(kind, vel, beat);
      levels_due = {levels_due, (known ? known_beat : beat)};
      beats_in++;
      @(negedge clock);
   endtask

   // Wait until every expected level has come back, then let the pipe go quiet
   task automatic settle();
      req_bus.valid = 1'b0;
      while (levels_due.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(input mseg_csr_type idx, input int unsigned value);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_data  = value[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_we = 1'b0;
      config_write(idx, value[CSR_DATA_W-1:0]);
   endtask

   function automatic int unsigned pick_len();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 3) return 0;
      if (r < 5) return LEN_MAX;
      if (r < 8) return $urandom_range(LEN_MAX);
      if (r < 30) return $urandom_range(40, 9);
      return $urandom_range(8, 0);
   endfunction

   // Random register setting per phase; two phases pin the floor and the ceiling
   task automatic program_phase(input int phase);
      int unsigned r;
      mseg_csr_type idx;
      for (int i = 0; i <= CSR_SUSTAIN_LEVEL; i++) begin
         idx = mseg_csr_type'(i);
         case (idx)
            CSR_SHAPE_MODE: begin
               if (phase == 4) r = MODE_ADHR;
               else if (phase == 5) r = MODE_RAMP;
               else if (phase < 4) r = phase;
               else r = $urandom_range(MODE_VELOCITY);
            end
            CSR_PEAK_LEVEL: begin
               r = $urandom_range(99);
               if (phase == 4 || r < 10) r = 16'h8000;
               else if (phase == 5 || r < 20) r = 16'h7FFF;
               else r = $urandom_range(16'hFFFF);
            end
            CSR_SUSTAIN_LEVEL: begin
               r = $urandom_range(99);
               if (phase == 4 || r < 8) r = 0;
               else if (phase == 5 || r < 15) r = 16'hFFFF;
               else if (r < 25) r = 32768;
               else if (r < 75) r = $urandom_range(32768);
               else r = $urandom_range(16'hFFFF);
            end
            default: begin
               if (phase == 4) r = 0;
               else if (phase == 5) r = LEN_MAX;
               else r = pick_len();
            end
         endcase
         write_reg(idx, r);
      end
   endtask

   // Result side: random ready, plus one long hold-off to back the block up
   initial begin
      rsp_bus.ready = 1'b0;
      stall_done    = 1'b0;
      forever begin
         @(negedge clock);
         if (!reset && !stall_done && beats_in >= 300) begin
            rsp_bus.ready = 1'b0;
            repeat (500) @(negedge clock);
            stall_done = 1'b1;
         end
         rsp_bus.ready = !reset && (calm || $urandom_range(99) >= 22);
      end
   end

   // Compare each result beat with the oldest expected level
   always @(posedge clock) begin : check_levels
      level_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (levels_due.size() == 0) begin
            $error("result beat with nothing expected: level %0d", rsp_bus.level);
            failures++;
         end else begin
            want = levels_due.pop_front();
            if (rsp_bus.level !== want.level) begin
               $error("level: expected %0d, got %0d", want.level, rsp_bus.level);
               failures++;
            end
            if (rsp_bus.expired !== want.expired) begin
               $error("expired: expected %0b, got %0b", want.expired, rsp_bus.expired);
               failures++;
            end
            if (rsp_bus.active !== want.active) begin
               $error("active: expected %0b, got %0b", want.active, rsp_bus.active);
               failures++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      int n;
      int span;
      int k;
      bit paused;
      level_beat_type none;
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_data         = '0;
      req_bus.valid    = 1'b0;
      req_bus.kind     = KIND_TRIGGER;
      req_bus.velocity = '0;
      beats_in         = 0;
      failures         = 0;
      cycles           = 0;
      paused           = 1'b0;
      none             = '0;
      cfg_mode    = MODE_ADHR;
      cfg_attack  = 480;
      cfg_decay   = 4800;
      cfg_release = 9600;
      cfg_hold    = 4800;
      cfg_ramp    = 24000;
      cfg_peak    = 32767;
      cfg_sustain = 9830;
      env_count   = '0;
      env_on      = 1'b0;
      env_vel     = '0;

      // reset defaults: idle tick, then attack start
      add_known(KIND_TICK, 0, 0, 1'b0, 1'b0);
      add_known(KIND_TRIGGER, 127, 0, 1'b0, 1'b1);
      add_item(KIND_TICK, 0);
      // velocity follower, zero hold counts as one sample, full velocity clamps
      add_write(CSR_SHAPE_MODE, MODE_VELOCITY);
      add_write(CSR_HOLD_LEN, 0);
      add_known(KIND_TRIGGER, 127, LVL_MAX, 1'b0, 1'b1);
      add_known(KIND_TICK, 0, 0, 1'b1, 1'b0);
      add_known(KIND_TICK, 0, 0, 1'b0, 1'b0);
      add_known(KIND_TRIGGER, 0, 0, 1'b0, 1'b1);
      add_item(KIND_TRIGGER, 64);
      // step at the negative extreme, retrigger restarts the count
      add_write(CSR_SHAPE_MODE, MODE_STEP);
      add_write(CSR_HOLD_LEN, 2);
      add_write(CSR_PEAK_LEVEL, 16'h8000);
      add_known(KIND_TRIGGER, 5, LVL_MIN, 1'b0, 1'b1);
      add_known(KIND_TICK, 0, LVL_MIN, 1'b0, 1'b1);
      add_known(KIND_TICK, 0, 0, 1'b1, 1'b0);
      // ramp with zero length expires at the peak
      add_write(CSR_SHAPE_MODE, MODE_RAMP);
      add_write(CSR_RAMP_LEN, 0);
      add_write(CSR_HOLD_LEN, 1);
      add_write(CSR_PEAK_LEVEL, 16'h7FFF);
      add_item(KIND_TRIGGER, 99);
      add_known(KIND_TICK, 0, LVL_MAX, 1'b0, 1'b1);
      add_known(KIND_TICK, 0, LVL_MAX, 1'b1, 1'b0);
      // envelope with minimum segments and sustain above one
      add_write(CSR_SHAPE_MODE, MODE_ADHR);
      add_write(CSR_ATTACK_LEN, 0);
      add_write(CSR_DECAY_LEN, 0);
      add_write(CSR_HOLD_LEN, 0);
      add_write(CSR_RELEASE_LEN, 2);
      add_write(CSR_SUSTAIN_LEVEL, 16'hFFFF);
      add_item(KIND_TRIGGER, 1);
      add_item(KIND_TICK, 0);
      add_item(KIND_TICK, 0);
      add_item(KIND_TICK, 0);
      add_known(KIND_TICK, 0, 0, 1'b1, 1'b0);
      // negative peak, sustain exactly one, release skipped
      add_write(CSR_PEAK_LEVEL, 16'h8000);
      add_write(CSR_SUSTAIN_LEVEL, 32768);
      add_write(CSR_RELEASE_LEN, 0);
      add_write(CSR_ATTACK_LEN, 3);
      add_write(CSR_DECAY_LEN, 2);
      add_write(CSR_HOLD_LEN, 1);
      add_known(KIND_TRIGGER, 33, 0, 1'b0, 1'b1);
      for (int i = 0; i < 5; i++) add_item(KIND_TICK, 0);
      add_known(KIND_TICK, 0, 0, 1'b1, 1'b0);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed script
      foreach (script[i]) begin
         if (script[i].is_write) begin
            settle();
            write_reg(script[i].idx, script[i].data);
         end else begin
            offer(script[i].kind, script[i].vel, script[i].known, script[i].beat);
         end
      end

      // random phases: mostly trigger followed by ticks until expiry, some noise
      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         program_phase(phase);
         n = 0;
         while (n < PHASE_ITEMS) begin
            if ($urandom_range(99) < 10) begin
               offer(1'($urandom_range(1)), VEL_W'($urandom_range(127)), 1'b0, none);
               n++;
            end else begin
               offer(KIND_TRIGGER, VEL_W'($urandom_range(127)), 1'b0, none);
               n++;
               // a short span cuts the note and retriggers it while running
               span = ($urandom_range(99) < 15) ? $urandom_range(3) : $urandom_range(60, 4);
               k = 0;
               while (env_on && k < span) begin
                  offer(KIND_TICK, VEL_W'($urandom_range(127)), 1'b0, none);
                  n++;
                  k++;
               end
               if (!env_on) begin
                  repeat ($urandom_range(2)) begin
                     offer(KIND_TICK, VEL_W'($urandom_range(127)), 1'b0, none);
                     n++;
                  end
               end
            end
            // sender pause until the pipe has fully drained
            if (phase == 6 && n >= PHASE_ITEMS / 2 && !paused) begin
               settle();
               paused = 1'b1;
            end
         end
      end

      req_bus.valid = 1'b0;
      while (levels_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/mseg_pkg.sv
rtl/core/mseg_req_if.sv
rtl/core/mseg_rsp_if.sv
rtl/core/mseg_queue.sv
rtl/core/mseg_front.sv
rtl/core/mseg_back.sv
rtl/core/multi_shape_envelope_generator.sv
test/tb_top.sv
